FILE: rtl/core/rc4_pkg.sv
// Shared types and constants for the RC4 stream cipher unit.
// No dependencies; imported by the core, the port checker and the testbench.
`timescale 1ns / 1ps

package rc4_pkg;

  localparam int SBOX_DEPTH = 256;
  localparam int BYTE_W     = 8;
  localparam int ADDR_W     = 8;
  localparam int LEN_W      = 9;

  localparam logic [LEN_W-1:0]  KEY_LEN_RESET = 9'd16;
  localparam logic [LEN_W-1:0]  KEY_LEN_MAX   = 9'd256;
  localparam logic [ADDR_W-1:0] LAST_ADDR     = 8'd255;

  // func codes
  localparam logic FUNC_KEY  = 1'b0;
  localparam logic FUNC_DATA = 1'b1;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,  // accept; issues read of S[i+1]
    S_FILL  = 10'b00_0000_0010,  // identity sweep of the S-box
    S_KS_RD = 10'b00_0000_0100,  // schedule: read S[n] and K[kpos]
    S_KS_J  = 10'b00_0000_1000,  // schedule: new j, read S[j]
    S_KS_WN = 10'b00_0001_0000,  // schedule: S[n] <= S[j]
    S_KS_WJ = 10'b00_0010_0000,  // schedule: S[j] <= old S[n]
    S_RD_J  = 10'b00_0100_0000,  // keystream: j += S[i], read S[j]
    S_SWAP  = 10'b00_1000_0000,  // keystream: S[i] <= S[j], read S[t]
    S_FIN   = 10'b01_0000_0000,  // keystream: S[j] <= S[i], form result
    S_OUT   = 10'b10_0000_0000   // result waits for the output register
  } state_t;

endpackage

FILE: rtl/core/rc4_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; used for the S-box and the key store.
`timescale 1ns / 1ps

module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on an address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/rc4_stream_cipher_unit.sv
// RC4 stream cipher unit: key load, key schedule and keystream XOR, one byte per word.
// Data word with key: S_RD_J, S_SWAP, S_FIN, then the output register; without: S_OUT.
// A new data word is taken only back in S_IDLE, after the three S-box reads and two swap
//   writes of one keystream step, which share the single S-box RAM read and write ports.
// Key word: stays in S_IDLE; the last starts S_FILL, then S_KS_RD to S_KS_WJ per entry.
// Reset (rst, synchronous): indices cleared, no key, key_length = 16, RAMs untouched.
`timescale 1ns / 1ps

module rc4_stream_cipher_unit
  import rc4_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // input words
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              func,
  input  logic [ADDR_W-1:0] key_index,
  input  logic [BYTE_W-1:0] key_byte,
  input  logic              key_last,
  input  logic [BYTE_W-1:0] data_byte,
  // result words
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] data_out,
  output logic              no_key,
  // key_length register write
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LEN_W-1:0]  key_length
);

  state_t state, state_next;

  // control
  logic              key_ready;
  logic [LEN_W-1:0]  key_len;
  logic [ADDR_W-1:0] index_i, index_i_next;
  logic [ADDR_W-1:0] index_j, index_j_next;
  logic [ADDR_W-1:0] cnt, cnt_next;     // fill / schedule position n
  logic [ADDR_W-1:0] kpos, kpos_next;   // key store position
  // datapath
  logic [BYTE_W-1:0] s_i, s_i_next;     // S[i] (or S[n] in the schedule)
  logic [BYTE_W-1:0] s_j, s_j_next;     // S[j] after its read
  logic [ADDR_W-1:0] t_addr, t_addr_next;
  logic [BYTE_W-1:0] data_q;
  logic [BYTE_W-1:0] res, res_next;
  logic              res_nokey, res_nokey_next;

  // RAM ports
  logic              s_we;
  logic [ADDR_W-1:0] s_waddr, s_raddr;
  logic [BYTE_W-1:0] s_wdata, s_rdata;
  logic              k_we;
  logic [BYTE_W-1:0] k_rdata;

  logic              in_fire, out_free;
  logic [LEN_W-1:0]  len_eff;
  logic [LEN_W-1:0]  kpos_inc;
  logic [BYTE_W-1:0] ks_byte;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  // key_length only changes between schedules, never under a running one
  assign cfg_ready = (state == S_IDLE);

  // zero means one, anything above 256 means 256
  always_comb begin
    if (key_len == '0) begin
      len_eff = LEN_W'(1);
    end else if (key_len > KEY_LEN_MAX) begin
      len_eff = KEY_LEN_MAX;
    end else begin
      len_eff = key_len;
    end
  end

  assign kpos_inc = {1'b0, kpos} + LEN_W'(1);

  // Keystream byte S[t], forwarded past the two swap writes that may still
  // be in flight: S[j] was just written with old S[i], S[i] with old S[j].
  always_comb begin
    if (t_addr == index_j) begin
      ks_byte = s_i;
    end else if (t_addr == index_i) begin
      ks_byte = s_j;
    end else begin
      ks_byte = s_rdata;
    end
  end

  // S-box port steering
  always_comb begin
    s_we    = 1'b0;
    s_waddr = cnt;
    s_wdata = cnt;
    s_raddr = cnt;
    unique case (state)
      S_IDLE: begin
        s_raddr = index_i + ADDR_W'(1);
      end
      S_FILL: begin
        s_we = 1'b1;
      end
      S_KS_RD: begin
        s_raddr = cnt;
      end
      S_KS_J: begin
        s_raddr = index_j + s_rdata + k_rdata;
      end
      S_KS_WN: begin
        s_we    = 1'b1;
        s_wdata = s_rdata;
      end
      S_KS_WJ: begin
        s_we    = 1'b1;
        s_waddr = index_j;
        s_wdata = s_i;
      end
      S_RD_J: begin
        s_raddr = index_j + s_rdata;
      end
      S_SWAP: begin
        s_we    = 1'b1;
        s_waddr = index_i;
        s_wdata = s_rdata;
        s_raddr = s_i + s_rdata;
      end
      S_FIN: begin
        s_we    = 1'b1;
        s_waddr = index_j;
        s_wdata = s_i;
      end
      S_OUT: begin
        s_raddr = cnt;
      end
      default: begin
        s_we = 1'b0;
      end
    endcase
  end

  assign k_we = in_fire && (func == FUNC_KEY);

  rc4_ram #(.WIDTH(BYTE_W), .DEPTH(SBOX_DEPTH)) u_sbox (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  rc4_ram #(.WIDTH(BYTE_W), .DEPTH(SBOX_DEPTH)) u_key_store (
    .clk   (clk),
    .we    (k_we),
    .waddr (key_index),
    .wdata (key_byte),
    .raddr (kpos),
    .rdata (k_rdata)
  );

  // sequencer
  always_comb begin
    state_next     = state;
    index_i_next   = index_i;
    index_j_next   = index_j;
    cnt_next       = cnt;
    kpos_next      = kpos;
    s_i_next       = s_i;
    s_j_next       = s_j;
    t_addr_next    = t_addr;
    res_next       = res;
    res_nokey_next = res_nokey;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (func == FUNC_DATA) begin
            if (key_ready) begin
              index_i_next = index_i + ADDR_W'(1);
              state_next   = S_RD_J;
            end else begin
              res_next       = data_byte;
              res_nokey_next = 1'b1;
              state_next     = S_OUT;
            end
          end else if (key_last) begin
            cnt_next   = '0;
            kpos_next  = '0;
            state_next = S_FILL;
          end
        end
      end
      S_FILL: begin
        cnt_next = cnt + ADDR_W'(1);
        if (cnt == LAST_ADDR) begin
          index_j_next = '0;
          state_next   = S_KS_RD;
        end
      end
      S_KS_RD: begin
        state_next = S_KS_J;
      end
      S_KS_J: begin
        s_i_next     = s_rdata;
        index_j_next = index_j + s_rdata + k_rdata;
        state_next   = S_KS_WN;
      end
      S_KS_WN: begin
        state_next = S_KS_WJ;
      end
      S_KS_WJ: begin
        cnt_next  = cnt + ADDR_W'(1);
        kpos_next = (kpos_inc >= len_eff) ? '0 : kpos_inc[ADDR_W-1:0];
        if (cnt == LAST_ADDR) begin
          index_i_next = '0;
          index_j_next = '0;
          state_next   = S_IDLE;
        end else begin
          state_next = S_KS_RD;
        end
      end
      S_RD_J: begin
        s_i_next     = s_rdata;
        index_j_next = index_j + s_rdata;
        state_next   = S_SWAP;
      end
      S_SWAP: begin
        s_j_next    = s_rdata;
        t_addr_next = s_i + s_rdata;
        state_next  = S_FIN;
      end
      S_FIN: begin
        res_next       = data_q ^ ks_byte;
        res_nokey_next = 1'b0;
        state_next     = out_free ? S_IDLE : S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      key_ready <= 1'b0;
      key_len   <= KEY_LEN_RESET;
      index_i   <= '0;
      index_j   <= '0;
      cnt       <= '0;
      kpos      <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      index_i <= index_i_next;
      index_j <= index_j_next;
      cnt     <= cnt_next;
      kpos    <= kpos_next;
      if (cfg_valid && cfg_ready) begin
        key_len <= key_length;
      end
      if (state == S_KS_WJ && cnt == LAST_ADDR) begin
        key_ready <= 1'b1;
      end
      // result register: loaded from the finish step or the holding state
      if ((state == S_FIN || state == S_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    s_i       <= s_i_next;
    s_j       <= s_j_next;
    t_addr    <= t_addr_next;
    res       <= res_next;
    res_nokey <= res_nokey_next;
    if (in_fire) begin
      data_q <= data_byte;
    end
    if ((state == S_FIN || state == S_OUT) && out_free) begin
      data_out <= res_next;
      no_key   <= res_nokey_next;
    end
  end

endmodule

FILE: rtl/core/rc4_checker.sv
// Port-level checker for the RC4 stream cipher unit, bound to the top level.
// Depends on rc4_pkg and the rc4_stream_cipher_unit port list.
`timescale 1ns / 1ps

module rc4_checker
  import rc4_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              func,
  input logic              key_last,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] data_out,
  input logic              no_key
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_out) && $stable(no_key))
    else $error("result word changed while stalled");

  // reset empties the result register
  a_rst_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // a data word or a last key word keeps the unit busy for the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (func == FUNC_DATA || key_last) |=> !in_ready)
    else $error("input taken while a step or schedule runs");

endmodule

bind rc4_stream_cipher_unit rc4_checker u_rc4_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .func      (func),
  .key_last  (key_last),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .data_out  (data_out),
  .no_key    (no_key)
);

FILE: tb/rc4_stream_cipher_unit_tb.sv
// Self-checking testbench for rc4_stream_cipher_unit: directed and random key/data words,
// with a keystream predictor in a small scoreboard class. Depends on rc4_pkg.
`timescale 1ns / 1ps

module rc4_stream_cipher_unit_tb;
  import rc4_pkg::*;

  localparam int SCHED_CYCLES = 1400;     // key schedule plus margin
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              no_key;
  } keystream_word_t;

  // Keystream predictor plus the queue of results still owed by the block.
  class rc4_scoreboard;
    bit [7:0]        perm [SBOX_DEPTH];
    bit [7:0]        key_mem [SBOX_DEPTH];
    bit [7:0]        pos_i;
    bit [7:0]        pos_j;
    bit              keyed;
    bit [LEN_W-1:0]  len_reg;
    keystream_word_t expected_q [$];
    int              n_fail;

    function new();
      len_reg = KEY_LEN_RESET;
      keyed   = 1'b0;
      pos_i   = '0;
      pos_j   = '0;
      n_fail  = 0;
    endfunction

    function int eff_len();
      if (len_reg == '0) return 1;
      if (len_reg > KEY_LEN_MAX) return SBOX_DEPTH;
      return int'(len_reg);
    endfunction

    function void set_key_length(bit [LEN_W-1:0] v);
      len_reg = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void schedule_key();
      int       len;
      int       n;
      int       kpos;
      bit [7:0] j;
      bit [7:0] swap;
      len  = eff_len();
      kpos = 0;
      j    = '0;
      for (n = 0; n < SBOX_DEPTH; n++) perm[n] = 8'(n);
      for (n = 0; n < SBOX_DEPTH; n++) begin
        j       = j + perm[n] + key_mem[kpos];
        swap    = perm[n];
        perm[n] = perm[j];
        perm[j] = swap;
        kpos++;
        if (kpos >= len) kpos = 0;
      end
      pos_i = '0;
      pos_j = '0;
      keyed = 1'b1;
    endfunction

    // Called at the edge where an input word is accepted.
    function void note_word(logic fn, logic [7:0] kidx, logic [7:0] kbyte, logic klast,
                            logic [7:0] din);
      bit [7:0]        swap;
      bit [7:0]        t;
      keystream_word_t w;
      if (fn == FUNC_KEY) begin
        key_mem[kidx] = kbyte;
        if (klast) schedule_key();
        return;
      end
      if (!keyed) begin
        // no key yet: pass-through, indices stay put
        w.data   = din;
        w.no_key = 1'b1;
      end else begin
        pos_i       = pos_i + 8'd1;
        pos_j       = pos_j + perm[pos_i];
        swap        = perm[pos_i];
        perm[pos_i] = perm[pos_j];
        perm[pos_j] = swap;
        t           = perm[pos_i] + perm[pos_j];
        w.data      = din ^ perm[t];
        w.no_key    = 1'b0;
      end
      expected_q.insert(expected_q.size(), w);
    endfunction

    task report(string what);
      $display("ERROR: %s", what);
      n_fail++;
    endtask

    task check_word(logic [7:0] dout, logic nk);
      keystream_word_t w;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing expected: data_out=%02h no_key=%0b", dout, nk));
        return;
      end
      w = expected_q.pop_front();
      if (dout !== w.data)
        report($sformatf("data_out %02h, expected %02h", dout, w.data));
      if (nk !== w.no_key)
        report($sformatf("no_key %0b, expected %0b", nk, w.no_key));
    endtask

    task flush_check();
      if (expected_q.size() != 0)
        report($sformatf("%0d results never arrived", expected_q.size()));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              func = FUNC_KEY;
  logic [ADDR_W-1:0] key_index = '0;
  logic [BYTE_W-1:0] key_byte = '0;
  logic              key_last = 1'b0;
  logic [BYTE_W-1:0] data_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [BYTE_W-1:0] data_out;
  logic              no_key;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [LEN_W-1:0]  key_length = KEY_LEN_RESET;

  rc4_scoreboard sb;
  bit            key_loaded [SBOX_DEPTH];  // key store entries written since reset
  int            words_sent = 0;
  int            in_idle_pct = 0;
  int            out_stall_pct = 0;
  int            cycles = 0;

  rc4_stream_cipher_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .key_index  (key_index),
    .key_byte   (key_byte),
    .key_last   (key_last),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .data_out   (data_out),
    .no_key     (no_key),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .key_length (key_length)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: check on handshake, then pick ready for the next cycle.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_word(data_out, no_key);
    out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  // Sends one word; leaves valid high so a following word goes out back to back.
  // Callers always reach here aligned to a rising edge.
  task send_word(logic fn, logic [7:0] kidx, logic [7:0] kbyte, logic klast, logic [7:0] din);
    while (in_idle_pct > 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    func      <= fn;
    key_index <= kidx;
    key_byte  <= kbyte;
    key_last  <= klast;
    data_byte <= din;
    do @(posedge clk); while (!in_ready);
    sb.note_word(fn, kidx, kbyte, klast, din);
    if (fn == FUNC_KEY) key_loaded[kidx] = 1'b1;
    words_sent++;
  endtask

  // Drop valid and hold off until every owed result is back.
  task drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Register write only when the block is quiet; a trailing schedule may still run.
  task write_key_length(bit [LEN_W-1:0] v);
    drain_results();
    repeat (SCHED_CYCLES) @(posedge clk);
    cfg_valid  <= 1'b1;
    key_length <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_key_length(v);
  endtask

  // Well-formed key load: fill any entry the schedule would read that was never
  // written, a few random overwrites, then the last word at any index.
  task rekey();
    int len;
    int k;
    len = sb.eff_len();
    for (k = 0; k < len; k++)
      if (!key_loaded[k])
        send_word(FUNC_KEY, 8'(k), 8'($urandom_range(0, 255)), 1'b0, 8'($urandom_range(0, 255)));
    repeat ($urandom_range(0, 3))
      send_word(FUNC_KEY, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0,
                8'($urandom_range(0, 255)));
    send_word(FUNC_KEY, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1,
              8'($urandom_range(0, 255)));
  endtask

  task run_phase(bit [LEN_W-1:0] len_val, int in_pct, int out_pct, int count);
    int  start;
    int  pick;
    bit  paused;
    write_key_length(len_val);
    in_idle_pct   = in_pct;
    out_stall_pct = out_pct;
    start         = words_sent;
    paused        = 1'b0;
    rekey();
    while (words_sent - start < count) begin
      // once per phase the sender waits for the pipeline to empty
      if (!paused && words_sent - start >= count / 2) begin
        paused = 1'b1;
        drain_results();
      end
      pick = $urandom_range(0, 99);
      if (pick < 8)
        rekey();
      else if (pick < 16)  // stray key byte, no schedule
        send_word(FUNC_KEY, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0,
                  8'($urandom_range(0, 255)));
      else                  // data; key_last is random and must be ignored
        send_word(FUNC_DATA, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // data before any key: passes through flagged, key_last ignored
    send_word(FUNC_DATA, 8'hFF, 8'hFF, 1'b1, 8'h00);
    send_word(FUNC_DATA, 8'h00, 8'h00, 1'b0, 8'hFF);
    send_word(FUNC_DATA, 8'hA5, 8'h5A, 1'b0, 8'h5A);

    // zero length acts as one byte
    write_key_length('0);
    send_word(FUNC_KEY, 8'h00, 8'hFF, 1'b0, 8'h00);
    send_word(FUNC_KEY, 8'hFF, 8'h00, 1'b0, 8'hFF);
    send_word(FUNC_KEY, 8'h00, 8'h00, 1'b1, 8'h00);
    send_word(FUNC_DATA, 8'h00, 8'h00, 1'b0, 8'h00);
    send_word(FUNC_DATA, 8'h00, 8'h00, 1'b0, 8'hFF);
    send_word(FUNC_DATA, 8'h00, 8'h00, 1'b0, 8'h01);
    send_word(FUNC_DATA, 8'hFF, 8'hFF, 1'b1, 8'h80);
    // rekey in mid stream: indices restart
    send_word(FUNC_KEY, 8'h00, 8'hFF, 1'b1, 8'hFF);
    send_word(FUNC_DATA, 8'h00, 8'h00, 1'b0, 8'h00);
    send_word(FUNC_DATA, 8'h00, 8'h00, 1'b0, 8'h00);
    send_word(FUNC_DATA, 8'h12, 8'h34, 1'b0, 8'hFF);
    // last byte at the top index; schedule still uses entry zero
    send_word(FUNC_KEY, 8'hFF, 8'h80, 1'b1, 8'h00);
    send_word(FUNC_DATA, 8'h00, 8'h00, 1'b1, 8'h55);
    send_word(FUNC_DATA, 8'h00, 8'h00, 1'b0, 8'hAA);

    run_phase(9'd1, 0, 0, 60);
    run_phase(KEY_LEN_MAX, 51, 0, 300);   // full key store load
    run_phase(9'h1FF, 0, 51, 60);         // above max clamps to 256
    run_phase(9'd5, 23, 23, 70);
    run_phase(9'($urandom_range(2, 255)), 0, 0, 50);

    drain_results();
    repeat (SCHED_CYCLES) @(posedge clk);
    sb.flush_check();
    if (sb.n_fail == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
